// ----- rtl/sgr_pkg.sv -----
// Types and constants shared by the SGR color tracker modules.
package sgr_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_SKIP = 2'd2,
        MODE_CSI  = 2'd3
    } t_mode;

    localparam int unsigned CHAR_W  = 16;
    localparam int unsigned COLOR_W = 6;
    localparam int unsigned PARAM_W = 8;

    localparam logic [CHAR_W-1:0] CH_NUL      = 16'd0;
    localparam logic [CHAR_W-1:0] CH_ESC      = 16'd27;
    localparam logic [CHAR_W-1:0] CH_LBRACKET = 16'd91;
    localparam logic [CHAR_W-1:0] CH_M        = 16'd109;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 16'd48;
    localparam logic [CHAR_W-1:0] CH_NINE     = 16'd57;

    localparam logic [PARAM_W-1:0] PARAM_MAX   = 8'd255;
    localparam logic [PARAM_W-1:0] SGR_RESET   = 8'd0;
    localparam logic [PARAM_W-1:0] SGR_BOLD    = 8'd1;
    localparam logic [PARAM_W-1:0] SGR_FG_LO   = 8'd30;
    localparam logic [PARAM_W-1:0] SGR_FG_HI   = 8'd37;
    localparam logic [PARAM_W-1:0] SGR_BG_LO   = 8'd40;
    localparam logic [PARAM_W-1:0] SGR_BG_HI   = 8'd47;

    localparam logic [COLOR_W-1:0] FG_BASE = 6'd30;
    localparam logic [COLOR_W-1:0] BG_BASE = 6'd40;
    localparam logic [2:0]         FG_RESET_IDX = 3'd7;
    localparam logic [2:0]         BG_RESET_IDX = 3'd0;

    typedef struct packed {
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic               bold_on;
        logic               in_sequence;
    } t_result;

endpackage

// ----- rtl/sgr_core.sv -----
// Escape sequence parser state and color state update for one character.
module sgr_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [sgr_pkg::CHAR_W-1:0]    i_char,
    output sgr_pkg::t_result              o_result
);
    import sgr_pkg::*;

    t_mode              r_mode, n_mode;
    logic [PARAM_W-1:0] r_param, n_param;
    logic               r_seen, n_seen;
    logic [2:0]         r_fg, n_fg;
    logic [2:0]         r_bg, n_bg;
    logic               r_bold, n_bold;

    logic               w_digit;
    logic               w_is_end;
    logic [11:0]        w_acc;
    logic [PARAM_W-1:0] w_fg_off;

    assign w_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign w_is_end = (i_char == CH_NUL) || (i_char == CH_M);
    assign w_acc    = {1'b0, r_param, 3'b000} + {3'b000, r_param, 1'b0}
                    + {8'd0, i_char[3:0]};
    assign w_fg_off = r_param - SGR_FG_LO;

    // next parse mode
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_IDLE: begin
                if (i_char == CH_ESC) n_mode = MODE_ESC;
            end
            MODE_ESC: begin
                if (i_char == CH_NUL)           n_mode = MODE_IDLE;
                else if (i_char == CH_LBRACKET) n_mode = MODE_CSI;
                else                            n_mode = MODE_SKIP;
            end
            MODE_SKIP: begin
                if (w_is_end) n_mode = MODE_IDLE;
            end
            MODE_CSI: begin
                if (!w_digit && w_is_end) n_mode = MODE_IDLE;
            end
            default: n_mode = MODE_IDLE;
        endcase
    end

    // parameter accumulation and color update
    always_comb begin
        n_param = r_param;
        n_seen  = r_seen;
        n_fg    = r_fg;
        n_bg    = r_bg;
        n_bold  = r_bold;
        if (r_mode == MODE_ESC && i_char == CH_LBRACKET) begin
            n_param = '0;
            n_seen  = 1'b0;
        end else if (r_mode == MODE_CSI) begin
            if (w_digit) begin
                n_param = (w_acc > {4'd0, PARAM_MAX}) ? PARAM_MAX : w_acc[PARAM_W-1:0];
                n_seen  = 1'b1;
            end else begin
                n_param = '0;
                n_seen  = 1'b0;
                if (r_seen) begin
                    if (r_param == SGR_RESET) begin
                        n_fg   = FG_RESET_IDX;
                        n_bg   = BG_RESET_IDX;
                        n_bold = 1'b0;
                    end else if (r_param == SGR_BOLD) begin
                        n_bold = 1'b1;
                    end else if (r_param >= SGR_FG_LO && r_param <= SGR_FG_HI) begin
                        n_fg = w_fg_off[2:0];
                    end else if (r_param >= SGR_BG_LO && r_param <= SGR_BG_HI) begin
                        n_bg = r_param[2:0];
                    end
                end
            end
        end
    end

    // result after this character
    always_comb begin
        o_result.fg_color    = FG_BASE + {3'b000, n_fg};
        o_result.bg_color    = BG_BASE + {3'b000, n_bg};
        o_result.bold_on     = n_bold;
        o_result.in_sequence = (n_mode != MODE_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_param <= '0;
            r_seen  <= 1'b0;
            r_fg    <= FG_RESET_IDX;
            r_bg    <= BG_RESET_IDX;
            r_bold  <= 1'b0;
        end else if (i_advance) begin
            r_mode  <= n_mode;
            r_param <= n_param;
            r_seen  <= n_seen;
            r_fg    <= n_fg;
            r_bg    <= n_bg;
            r_bold  <= n_bold;
        end
    end

endmodule

// ----- rtl/ansi_sgr_color_tracker.sv -----
// Top level of the ANSI SGR color tracker: input register, parser, result register.
//
// Input channel: i_valid, i_character, o_stall. A character transfers at a
// rising edge with i_valid high and o_stall low.
// Output channel: o_valid, o_fg_color, o_bg_color, o_bold_on, o_in_sequence,
// i_stall. A result transfers at a rising edge with o_valid high and i_stall low.
// Every character yields exactly one result: the colors, bold and sequence
// status after that character.
// A character passes the input register, then the result register, on its way to
// o_valid. Throughput: one character per cycle while i_stall is low; the parser
// state update is combinational logic between the two registers.
// When the receiver stalls, the result register holds; the input register
// keeps taking one more character, then o_stall rises until the result moves.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to idle with foreground 37, background 40 and bold off.
module ansi_sgr_color_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [sgr_pkg::CHAR_W-1:0]      i_character,
    output logic                            o_stall,
    output logic                            o_valid,
    output logic [sgr_pkg::COLOR_W-1:0]     o_fg_color,
    output logic [sgr_pkg::COLOR_W-1:0]     o_bg_color,
    output logic                            o_bold_on,
    output logic                            o_in_sequence,
    input  logic                            i_stall
);
    import sgr_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_out_valid;
    t_result           r_result;
    t_result           w_result;
    logic              w_adv;
    logic              w_take;

    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !w_adv;
    assign w_take  = i_valid && !o_stall;

    sgr_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_adv),
        .i_char    (r_char),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take)       r_in_valid <= 1'b1;
            else if (w_adv)   r_in_valid <= 1'b0;
            if (w_adv)        r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_char <= i_character;
        if (w_adv)  r_result <= w_result;
    end

    assign o_valid       = r_out_valid;
    assign o_fg_color    = r_result.fg_color;
    assign o_bg_color    = r_result.bg_color;
    assign o_bold_on     = r_result.bold_on;
    assign o_in_sequence = r_result.in_sequence;

    a_fg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fg_color >= FG_BASE) && (o_fg_color <= FG_BASE + 6'd7))
        else $error("foreground code out of range");

    a_bg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bg_color >= BG_BASE) && (o_bg_color <= BG_BASE + 6'd7))
        else $error("background code out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !w_adv)
        else $error("held result overwritten");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the ANSI SGR color tracker: directed table, random streams.
module tb_top;
    import sgr_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PRESSURE_AT  = 650;
    localparam int PRESSURE_LEN = 60;
    localparam int DIR_ROWS     = 28;
    localparam int IDLE_PCT     = 6;

    localparam logic [CHAR_W-1:0] CH_SEMI     = 16'd59;
    localparam logic [CHAR_W-1:0] CH_HIGH     = 16'h8000;
    localparam logic [CHAR_W-1:0] CH_ALL_ONES = 16'hFFFF;

    localparam t_result PLAIN  = '{6'd37, 6'd40, 1'b0, 1'b0};
    localparam t_result IN_SEQ = '{6'd37, 6'd40, 1'b0, 1'b1};

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              typed;
        t_result           want;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [CHAR_W-1:0]   i_character = '0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [COLOR_W-1:0]  o_fg_color;
    logic [COLOR_W-1:0]  o_bg_color;
    logic                o_bold_on;
    logic                o_in_sequence;

    t_dir_row          dir_rows [DIR_ROWS];
    t_result           color_expect_q [$];
    logic [CHAR_W-1:0] char_plan [$];

    t_mode             sgr_mode = MODE_IDLE;
    logic [PARAM_W-1:0] sgr_acc = '0;
    logic              sgr_acc_seen = 1'b0;
    logic [2:0]        fg_idx = FG_RESET_IDX;
    logic [2:0]        bg_idx = BG_RESET_IDX;
    logic              bold_flag = 1'b0;

    int tx_idle_pct = IDLE_PCT;
    int chars_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int input_hold_cycles = 0;
    int sgr_seq_count = 0;
    int skip_count = 0;
    int cycle_count = 0;

    ansi_sgr_color_tracker i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_character  (i_character),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .o_fg_color   (o_fg_color),
        .o_bg_color   (o_bg_color),
        .o_bold_on    (o_bold_on),
        .o_in_sequence(o_in_sequence),
        .i_stall      (i_stall)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results pending",
                   cycle_count, color_expect_q.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_result track_char(input logic [CHAR_W-1:0] ch);
        int      next;
        t_result r;
        case (sgr_mode)
            MODE_IDLE: begin
                if (ch == CH_ESC) sgr_mode = MODE_ESC;
            end
            MODE_ESC: begin
                if (ch == CH_NUL) begin
                    sgr_mode = MODE_IDLE;
                end else if (ch == CH_LBRACKET) begin
                    sgr_mode = MODE_CSI;
                    sgr_acc = '0;
                    sgr_acc_seen = 1'b0;
                end else begin
                    sgr_mode = MODE_SKIP;
                end
            end
            MODE_SKIP: begin
                if (ch == CH_NUL || ch == CH_M) sgr_mode = MODE_IDLE;
            end
            default: begin
                if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    next = int'(sgr_acc) * 10 + int'(ch - CH_ZERO);
                    sgr_acc = (next > int'(PARAM_MAX)) ? PARAM_MAX : PARAM_W'(next);
                    sgr_acc_seen = 1'b1;
                end else begin
                    if (sgr_acc_seen) begin
                        if (sgr_acc == SGR_RESET) begin
                            fg_idx = FG_RESET_IDX;
                            bg_idx = BG_RESET_IDX;
                            bold_flag = 1'b0;
                        end else if (sgr_acc == SGR_BOLD) begin
                            bold_flag = 1'b1;
                        end else if (sgr_acc >= SGR_FG_LO && sgr_acc <= SGR_FG_HI) begin
                            fg_idx = 3'(sgr_acc - SGR_FG_LO);
                        end else if (sgr_acc >= SGR_BG_LO && sgr_acc <= SGR_BG_HI) begin
                            bg_idx = 3'(sgr_acc - SGR_BG_LO);
                        end
                    end
                    sgr_acc = '0;
                    sgr_acc_seen = 1'b0;
                    if (ch == CH_NUL || ch == CH_M) sgr_mode = MODE_IDLE;
                end
            end
        endcase
        r.fg_color    = FG_BASE + COLOR_W'(fg_idx);
        r.bg_color    = BG_BASE + COLOR_W'(bg_idx);
        r.bold_on     = bold_flag;
        r.in_sequence = (sgr_mode != MODE_IDLE);
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] any_non_digit();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom); while (c >= CH_ZERO && c <= CH_NINE);
        return c;
    endfunction

    task automatic push_number(input int value);
        string s;
        s = $sformatf("%0d", value);
        if ($urandom_range(9) == 0) repeat ($urandom_range(1, 2)) char_plan.push_back(CH_ZERO);
        for (int i = 0; i < s.len(); i++) char_plan.push_back({8'd0, s[i]});
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic typed,
                             input t_result want);
        t_result predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_character <= ch;
        do @(posedge i_clk); while (o_stall);
        predicted = track_char(ch);
        color_expect_q.push_back(typed ? want : predicted);
        chars_sent++;
    endtask

    initial begin : result_side
        t_result got;
        t_result want;
        int      stall_left;
        bit      pressure_done;
        stall_left = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_valid && o_stall) input_hold_cycles++;
            if (i_rst_n && o_valid && !i_stall) begin
                got = '{o_fg_color, o_bg_color, o_bold_on, o_in_sequence};
                if (color_expect_q.size() == 0) begin
                    $error("result with no pending expectation: fg %0d bg %0d bold %0d seq %0d",
                           got.fg_color, got.bg_color, got.bold_on, got.in_sequence);
                    mismatch_count++;
                end else begin
                    want = color_expect_q.pop_front();
                    if (got.fg_color !== want.fg_color) begin
                        $error("fg_color: expected %0d, actual %0d", want.fg_color, got.fg_color);
                        mismatch_count++;
                    end
                    if (got.bg_color !== want.bg_color) begin
                        $error("bg_color: expected %0d, actual %0d", want.bg_color, got.bg_color);
                        mismatch_count++;
                    end
                    if (got.bold_on !== want.bold_on) begin
                        $error("bold_on: expected %0d, actual %0d", want.bold_on, got.bold_on);
                        mismatch_count++;
                    end
                    if (got.in_sequence !== want.in_sequence) begin
                        $error("in_sequence: expected %0d, actual %0d",
                               want.in_sequence, got.in_sequence);
                        mismatch_count++;
                    end
                end
                results_checked++;
            end
            // hold off once for a long stretch so the block backs up into its input
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!pressure_done && results_checked >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                stall_left = PRESSURE_LEN - 1;
                i_stall <= 1'b1;
            end else if (results_checked >= 200 && results_checked < 400) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin : char_side
        int                kind;
        int                count;
        logic [CHAR_W-1:0] c;
        dir_rows = '{
            '{CH_ALL_ONES,      1'b1, PLAIN},
            '{CH_ESC,           1'b1, IN_SEQ},
            '{CH_LBRACKET,      1'b1, IN_SEQ},
            '{CH_ZERO + 16'd1,  1'b0, '0},
            '{CH_SEMI,          1'b0, '0},
            '{CH_ZERO + 16'd3,  1'b0, '0},
            '{CH_ZERO + 16'd1,  1'b0, '0},
            '{CH_HIGH,          1'b0, '0},
            '{CH_ZERO + 16'd4,  1'b0, '0},
            '{CH_ZERO + 16'd7,  1'b0, '0},
            '{CH_M,             1'b0, '0},
            '{CH_ESC,           1'b0, '0},
            '{CH_LBRACKET,      1'b0, '0},
            '{CH_NINE,          1'b0, '0},
            '{CH_NINE,          1'b0, '0},
            '{CH_NINE,          1'b0, '0},
            '{CH_NUL,           1'b0, '0},
            '{CH_ESC,           1'b0, '0},
            '{CH_M,             1'b0, '0},
            '{CH_ESC,           1'b0, '0},
            '{CH_M,             1'b0, '0},
            '{CH_ESC,           1'b0, '0},
            '{CH_LBRACKET,      1'b0, '0},
            '{CH_SEMI,          1'b0, '0},
            '{CH_ZERO,          1'b0, '0},
            '{CH_M,             1'b1, PLAIN},
            '{CH_ESC,           1'b1, IN_SEQ},
            '{CH_NUL,           1'b1, PLAIN}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) send_char(dir_rows[k].ch, dir_rows[k].typed, dir_rows[k].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (char_plan.size() == 0) begin
                kind = $urandom_range(99);
                if (kind < 55) begin
                    char_plan.push_back(CH_ESC);
                    char_plan.push_back(CH_LBRACKET);
                    count = $urandom_range(1, 4);
                    for (int p = 0; p < count; p++) begin
                        if (p > 0)
                            char_plan.push_back(($urandom_range(99) < 85) ? CH_SEMI
                                                                          : any_non_digit());
                        case ($urandom_range(9))
                            0: ;
                            1: push_number(0);
                            2: push_number(1);
                            3, 4: push_number(30 + $urandom_range(7));
                            5, 6: push_number(40 + $urandom_range(7));
                            7: push_number($urandom_range(99));
                            8: push_number($urandom_range(256, 99999));
                            default: push_number($urandom_range(255));
                        endcase
                    end
                    char_plan.push_back(($urandom_range(9) == 0) ? CH_NUL : CH_M);
                    sgr_seq_count++;
                end else if (kind < 68) begin
                    repeat ($urandom_range(1, 6)) char_plan.push_back(CHAR_W'($urandom_range(32, 126)));
                end else if (kind < 80) begin
                    char_plan.push_back(CH_ESC);
                    case ($urandom_range(3))
                        0: char_plan.push_back(CH_M);
                        1: char_plan.push_back(CH_ESC);
                        default: begin
                            do c = CHAR_W'($urandom_range(32, 126)); while (c == CH_LBRACKET);
                            char_plan.push_back(c);
                        end
                    endcase
                    repeat ($urandom_range(4)) begin
                        do c = CHAR_W'($urandom_range(32, 126)); while (c == CH_M);
                        char_plan.push_back(($urandom_range(7) == 0) ? CH_ESC : c);
                    end
                    char_plan.push_back(CH_M);
                    skip_count++;
                end else if (kind < 93) begin
                    repeat ($urandom_range(1, 4)) begin
                        case ($urandom_range(7))
                            0, 1, 2: c = CHAR_W'($urandom);
                            3: c = CH_NUL;
                            4: c = CH_ESC;
                            5: c = CH_LBRACKET;
                            6: c = CH_M;
                            default: c = CH_ZERO + CHAR_W'($urandom_range(9));
                        endcase
                        char_plan.push_back(c);
                    end
                end else begin
                    // cut a sequence short
                    char_plan.push_back(CH_ESC);
                    case ($urandom_range(2))
                        0: char_plan.push_back(CH_NUL);
                        1: begin
                            char_plan.push_back(CH_LBRACKET);
                            push_number($urandom_range(60));
                            char_plan.push_back(CH_NUL);
                        end
                        default: begin
                            char_plan.push_back(CH_LBRACKET);
                            push_number($urandom_range(60));
                            char_plan.push_back(any_non_digit());
                        end
                    endcase
                end
            end
            tx_idle_pct = (n >= 180 && n < 380) ? 0 : IDLE_PCT;
            send_char(char_plan.pop_front(), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (color_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d characters sent, %0d results checked, %0d mismatches",
                 chars_sent, results_checked, mismatch_count);
        $display("%0d SGR sequences, %0d skipped sequences, %0d cycles of input backpressure",
                 sgr_seq_count, skip_count, input_hold_cycles);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
